// File: sv/rkcc_pkg.sv
// ----------------------------------------------------------------------------
// rkcc_pkg
// Shared types, constants and letter tables of the running key caesar cipher.
// ----------------------------------------------------------------------------
package rkcc_pkg;

   localparam int CODE_W           = 16;
   localparam int MULT_W           = 16;
   localparam int DIVISOR_W        = 16;
   localparam int KEY_BITS_DEF     = 32;
   localparam int MAX_ALPHABET_DEF = 34;
   localparam int TAB_CAP          = 34;
   localparam int TAB_IDX_W        = 6;
   localparam int TAB_ROWS         = 6;
   localparam int PAIR_W           = 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_KEY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MULTIPLIER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_DIVISOR     = 3'd4;

   localparam logic [PAIR_W-1:0] ALPHA_UKRAINIAN = 2'd0;
   localparam logic [PAIR_W-1:0] ALPHA_RUSSIAN   = 2'd1;
   localparam logic [PAIR_W-1:0] ALPHA_LATIN     = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0] char_code;
      logic              message_start;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] out_code;
      logic              was_letter;
   } rsp_type;

   localparam logic [CODE_W-1:0] LETTER_TAB [0:TAB_ROWS-1][0:TAB_CAP-1] = '{
      '{16'h0410, 16'h0491, 16'h0490, 16'h0411, 16'h0412, 16'h0413, 16'h0414,
        16'h0415, 16'h0404, 16'h0416, 16'h0417, 16'h0418, 16'h0406, 16'h0407,
        16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
        16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426,
        16'h0427, 16'h0428, 16'h0429, 16'h042C, 16'h042E, 16'h042F},
      '{16'h0491, 16'h0491, 16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434,
        16'h0435, 16'h0454, 16'h0436, 16'h0437, 16'h0438, 16'h0456, 16'h0457,
        16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
        16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446,
        16'h0447, 16'h0448, 16'h0449, 16'h044C, 16'h044E, 16'h044F},
      '{16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0401,
        16'h0416, 16'h0417, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C,
        16'h041D, 16'h041E, 16'h041F, 16'h0420, 16'h0421, 16'h0422, 16'h0423,
        16'h0424, 16'h0425, 16'h0426, 16'h0427, 16'h0428, 16'h0429, 16'h042A,
        16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F, 16'h0000},
      '{16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0451,
        16'h0436, 16'h0437, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C,
        16'h043D, 16'h043E, 16'h043F, 16'h0440, 16'h0441, 16'h0442, 16'h0443,
        16'h0444, 16'h0445, 16'h0446, 16'h0447, 16'h0448, 16'h0449, 16'h044A,
        16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F, 16'h0000},
      '{16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E,
        16'h004F, 16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055,
        16'h0056, 16'h0057, 16'h0058, 16'h0059, 16'h005A, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E,
        16'h006F, 16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075,
        16'h0076, 16'h0077, 16'h0078, 16'h0079, 16'h007A, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
   };

   function automatic logic [CODE_W-1:0] letter_code(input logic [PAIR_W:0] row,
                                                     input logic [TAB_IDX_W-1:0] idx);
      logic [CODE_W-1:0] code;
      code = '0;
      if ((int'(row) < TAB_ROWS) && (int'(idx) < TAB_CAP)) begin
         code = LETTER_TAB[row][idx];
      end
      return code;
   endfunction

   function automatic logic [TAB_IDX_W-1:0] letter_len(input logic [PAIR_W-1:0] pair);
      logic [TAB_IDX_W-1:0] len;
      case (pair)
         ALPHA_RUSSIAN: begin
            len = 6'd33;
         end
         ALPHA_LATIN: begin
            len = 6'd26;
         end
         default: begin
            len = 6'd34;
         end
      endcase
      return len;
   endfunction

endpackage

// File: sv/running_key_caesar_cipher.sv
// A letter runs through 16 multiplier-bit steps, KEY_BITS + 16 serial divider
// steps, a fix-up state and a done state before its result is registered; a
// non-letter goes straight from acceptance to the done state.
// Items are taken one at a time, the next only once the last result is
// registered; a result held by the receiver delays the next one.
// Reset (synchronous) clears the running key and loads the register defaults.
// ----------------------------------------------------------------------------
// running_key_caesar_cipher
// Progressive-shift caesar cipher over utf-16 code units with a bit-serial
// multiply and divide for the running shift.
// ----------------------------------------------------------------------------
module running_key_caesar_cipher #(
   parameter int KEY_BITS     = rkcc_pkg::KEY_BITS_DEF,
   parameter int MAX_ALPHABET = rkcc_pkg::MAX_ALPHABET_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rkcc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rkcc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [rkcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rkcc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rkcc_pkg::*;

   localparam int PROD_W = KEY_BITS + MULT_W;
   localparam int IDX_W  = $clog2(MAX_ALPHABET);
   localparam int MOD_W  = IDX_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // configuration
   logic [PAIR_W-1:0]    alpha_ff;
   logic                 decrypt_ff;
   logic [CODE_W-1:0]    start_key_ff;
   logic [MULT_W-1:0]    mult_ff;
   logic [DIVISOR_W-1:0] divisor_ff;

   logic [2:0]           state_ff, state_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [CODE_W-1:0]    code_ff;
   logic                 found_ff;
   logic                 lower_ff;
   logic [PAIR_W-1:0]    pair_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [MOD_W-1:0]     n_ff;
   logic [IDX_W-1:0]     ni_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [PAIR_W-1:0]    pair_cur;
   logic [MOD_W-1:0]     n_cur;
   logic                 hit_u, hit_l;
   logic [IDX_W-1:0]     idx_u, idx_l;
   logic [KEY_BITS-1:0]  key_sel;
   logic                 accept;
   logic                 out_load;
   logic [MOD_W:0]       ni_sum;
   logic [MOD_W-1:0]     ni_val;

   logic                 mul_done, div_done;
   logic [PROD_W-1:0]    product;
   logic [MOD_W-1:0]     shift_mod;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_UKRAINIAN;
         decrypt_ff   <= 1'b0;
         start_key_ff <= '0;
         mult_ff      <= MULT_W'(1);
         divisor_ff   <= DIVISOR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHABET_SELECT: begin
               alpha_ff <= csr_wdata[PAIR_W-1:0];
            end
            CSR_DECRYPT_MODE: begin
               decrypt_ff <= csr_wdata[0];
            end
            CSR_START_KEY: begin
               start_key_ff <= csr_wdata[CODE_W-1:0];
            end
            CSR_KEY_MULTIPLIER: begin
               mult_ff <= csr_wdata[MULT_W-1:0];
            end
            CSR_KEY_DIVISOR: begin
               divisor_ff <= csr_wdata[DIVISOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // letter search, upper table first
   always_comb begin
      pair_cur = (alpha_ff > ALPHA_LATIN) ? ALPHA_UKRAINIAN : alpha_ff;
      n_cur    = (int'(letter_len(pair_cur)) > MAX_ALPHABET) ? MOD_W'(MAX_ALPHABET)
                                                           : MOD_W'(letter_len(pair_cur));
      hit_u = 1'b0;
      hit_l = 1'b0;
      idx_u = '0;
      idx_l = '0;
      for (int i = 0; i < TAB_CAP; i++) begin
         if (!hit_u && (i < int'(n_cur)) &&
             (letter_code({pair_cur, 1'b0}, TAB_IDX_W'(i)) == req_data.char_code)) begin
            hit_u = 1'b1;
            idx_u = IDX_W'(i);
         end
         if (!hit_l && (i < int'(n_cur)) &&
             (letter_code({pair_cur, 1'b1}, TAB_IDX_W'(i)) == req_data.char_code)) begin
            hit_l = 1'b1;
            idx_l = IDX_W'(i);
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign key_sel   = req_data.message_start ? KEY_BITS'(start_key_ff) : key_ff;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ni_sum = decrypt_ff ? ({1'b0, MOD_W'(idx_ff)} + {1'b0, n_ff} - {1'b0, shift_mod})
                          : ({1'b0, MOD_W'(idx_ff)} + {1'b0, shift_mod});
      ni_val = (ni_sum >= {1'b0, n_ff}) ? MOD_W'(ni_sum - {1'b0, n_ff})
                                        : ni_sum[MOD_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = key_sel;
               state_in = (hit_u || hit_l) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
               if (found_ff) begin
                  key_in = key_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.was_letter = found_ff;
         rsp_data_in.out_code   = found_ff ?
            letter_code({pair_ff, lower_ff}, TAB_IDX_W'(ni_ff)) : code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff  <= req_data.char_code;
         found_ff <= hit_u || hit_l;
         lower_ff <= !hit_u;
         pair_ff  <= pair_cur;
         idx_ff   <= hit_u ? idx_u : idx_l;
         n_ff     <= n_cur;
      end
      if (state_ff == ST_FIX) begin
         ni_ff <= ni_val[IDX_W-1:0];
      end
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rkcc_mult #(
      .KEY_BITS (KEY_BITS)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .start      (accept && (hit_u || hit_l)),
      .key        (key_sel),
      .multiplier (mult_ff),
      .done       (mul_done),
      .product    (product)
   );

   rkcc_divmod #(
      .PROD_W (PROD_W),
      .MOD_W  (MOD_W)
   ) u_divmod (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_MUL) && mul_done),
      .dividend (product),
      .divisor  (divisor_ff),
      .modulus  (n_ff),
      .done     (div_done),
      .residue  (shift_mod)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a non-letter transfer comes out unchanged
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (out_load && !found_ff) |=> (rsp_data.out_code == $past(code_ff)) && !rsp_data.was_letter)
      else $error("non-letter code altered");

   // the running key only advances on a letter
   a_key_hold: assert property (@(posedge clock) disable iff (reset)
      (out_load && !found_ff) |=> (key_ff == $past(key_ff)))
      else $error("running key moved on a non-letter");

   // the shift residue stays below the alphabet length
   a_residue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (shift_mod < n_ff))
      else $error("shift residue out of range");
`endif

endmodule

// File: sv/rkcc_mult.sv
// ----------------------------------------------------------------------------
// rkcc_mult
// Bit-serial shift-add multiplier: running key times key multiplier, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rkcc_mult #(
   parameter int KEY_BITS = rkcc_pkg::KEY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [KEY_BITS-1:0]                 key,
   input  logic [rkcc_pkg::MULT_W-1:0]         multiplier,
   output logic                                done,
   output logic [KEY_BITS+rkcc_pkg::MULT_W-1:0] product
);
   import rkcc_pkg::*;

   localparam int PROD_W = KEY_BITS + MULT_W;
   localparam int CNT_W  = $clog2(MULT_W + 1);

   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [KEY_BITS:0]   sum;

   always_comb begin
      sum = {1'b0, acc_ff[PROD_W-1:MULT_W]} + (acc_ff[0] ? {1'b0, key_ff} : '0);
      acc_in  = acc_ff;
      key_in  = key_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = {{KEY_BITS{1'b0}}, multiplier};
         key_in = key;
         cnt_in = CNT_W'(MULT_W);
      end else if (cnt_ff != '0) begin
         acc_in  = {sum, acc_ff[MULT_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      key_ff <= key_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: sv/rkcc_divmod.sv
// ----------------------------------------------------------------------------
// rkcc_divmod
// Bit-serial restoring divider; the quotient bits are folded into a running
// residue modulo the alphabet length, so only the residue is kept.
// ----------------------------------------------------------------------------
module rkcc_divmod #(
   parameter int PROD_W = rkcc_pkg::KEY_BITS_DEF + rkcc_pkg::MULT_W,
   parameter int MOD_W  = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [PROD_W-1:0]                  dividend,
   input  logic [rkcc_pkg::DIVISOR_W-1:0]     divisor,
   input  logic [MOD_W-1:0]                   modulus,
   output logic                               done,
   output logic [MOD_W-1:0]                   residue
);
   import rkcc_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0]    sh_ff, sh_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [MOD_W-1:0]     n_ff, n_in;
   logic [MOD_W-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;
   logic [MOD_W-1:0]     q2;

   always_comb begin
      trial = {rem_ff, sh_ff[PROD_W-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});
      q2    = {q_ff[MOD_W-2:0], ge};
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in  = dividend;
         rem_in = '0;
         div_in = (divisor == '0) ? DIVISOR_W'(1) : divisor;
         n_in   = modulus;
         q_in   = '0;
         cnt_in = CNT_W'(PROD_W);
      end else if (cnt_ff != '0) begin
         sh_in   = {sh_ff[PROD_W-2:0], 1'b0};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         q_in    = (q2 >= n_ff) ? (q2 - n_ff) : q2;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign residue = q_ff;

endmodule

// File: bench/tb_running_key_caesar_cipher.sv
// ----------------------------------------------------------------------------
// tb_running_key_caesar_cipher
// Self-checking bench for the progressive-shift caesar cipher. A directed
// table covers pass-through codes, table wrap, the small letter held in the
// Ukrainian capital table, both shift directions and extreme key settings.
// Random messages follow under a series of register settings, with random
// request gaps and result stalls. Every result is compared against the
// table's expected value or an in-bench model of the cipher.
// ----------------------------------------------------------------------------
module tb_running_key_caesar_cipher;
   timeunit 1ns;
   timeprecision 1ps;

   import rkcc_pkg::*;

   localparam int          NUM_PHASES  = 12;
   localparam int          PHASE_ITEMS = 48;
   localparam int          HOLD_PHASE  = 5;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT = 400000;

   localparam int unsigned ALPHABET_LEN [0:2] = '{34, 33, 26};

   typedef struct packed {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] reg_sel;
      logic [CODE_W-1:0]    value;
      bit                   start;
      bit                   typed;
      rsp_type              want;
   } plan_row_type;

   localparam int PLAN_LEN = 34;
   localparam plan_row_type PLAN [0:PLAN_LEN-1] = '{
      '{1'b0, '0, 16'h0041, 1'b1, 1'b1, '{16'h0041, 1'b0}},
      '{1'b0, '0, 16'h0410, 1'b0, 1'b1, '{16'h0410, 1'b1}},
      '{1'b0, '0, 16'h0410, 1'b0, 1'b1, '{16'h0491, 1'b1}},
      '{1'b0, '0, 16'h0491, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h042F, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 1'b0}},
      '{1'b0, '0, 16'h044F, 1'b1, 1'b1, '{16'h044F, 1'b1}},
      '{1'b1, CSR_DECRYPT_MODE, 16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0410, 1'b1, 1'b1, '{16'h0410, 1'b1}},
      '{1'b0, '0, 16'h0410, 1'b0, 1'b1, '{16'h042F, 1'b1}},
      '{1'b1, CSR_ALPHABET_SELECT, 16'(ALPHA_RUSSIAN), 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0401, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0451, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h042A, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0490, 1'b0, 1'b1, '{16'h0490, 1'b0}},
      '{1'b0, '0, 16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0}},
      '{1'b1, CSR_ALPHABET_SELECT, 16'(ALPHA_LATIN), 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b1, CSR_START_KEY, 16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b1, CSR_KEY_MULTIPLIER, 16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0041, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h007A, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h0040, 1'b0, 1'b1, '{16'h0040, 1'b0}},
      '{1'b0, '0, 16'h005B, 1'b0, 1'b1, '{16'h005B, 1'b0}},
      '{1'b0, '0, 16'h0060, 1'b0, 1'b1, '{16'h0060, 1'b0}},
      '{1'b0, '0, 16'h007B, 1'b0, 1'b1, '{16'h007B, 1'b0}},
      '{1'b1, CSR_KEY_DIVISOR, 16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h005A, 1'b1, 1'b0, '{16'h0000, 1'b0}},
      '{1'b1, CSR_KEY_MULTIPLIER, 16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b0, '0, 16'h006D, 1'b1, 1'b1, '{16'h006D, 1'b1}},
      '{1'b1, CSR_DECRYPT_MODE, 16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b1, CSR_START_KEY, 16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b1, CSR_KEY_MULTIPLIER, 16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0}},
      '{1'b1, CSR_KEY_DIVISOR, 16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0}}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // cipher state as the bench sees it
   logic [PAIR_W-1:0]       sel_alpha;
   logic                    go_backward;
   logic [CODE_W-1:0]       key_seed;
   logic [MULT_W-1:0]       key_mul;
   logic [DIVISOR_W-1:0]    key_div;
   logic [KEY_BITS_DEF-1:0] key_now;

   rsp_type     pending_chars [$];
   int unsigned mismatches;
   int unsigned chars_sent;
   int unsigned letters_sent;
   int unsigned regs_written;
   int unsigned cycle_count;
   bit          calm;
   bit          hold_request;

   running_key_caesar_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic rsp_type encipher(input req_type item);
      int unsigned pair;
      int unsigned n;
      int unsigned row;
      int unsigned idx;
      int unsigned step;
      int unsigned pos;
      bit          found;
      logic [63:0] product;
      logic [63:0] divisor;
      rsp_type     res;
      pair  = (sel_alpha <= ALPHA_LATIN) ? sel_alpha : ALPHA_UKRAINIAN;
      n     = ALPHABET_LEN[pair];
      found = 1'b0;
      row   = 0;
      idx   = 0;
      if (item.message_start) begin
         key_now = KEY_BITS_DEF'(key_seed);
      end
      // capitals first, first hit wins
      for (int i = 0; i < n && !found; i++) begin
         if (LETTER_TAB[2 * pair][i] == item.char_code) begin
            row   = 2 * pair;
            idx   = i;
            found = 1'b1;
         end
      end
      for (int i = 0; i < n && !found; i++) begin
         if (LETTER_TAB[2 * pair + 1][i] == item.char_code) begin
            row   = 2 * pair + 1;
            idx   = i;
            found = 1'b1;
         end
      end
      res.out_code   = item.char_code;
      res.was_letter = 1'b0;
      if (found) begin
         divisor = (key_div == 0) ? 64'd1 : 64'(key_div);
         product = 64'(key_now) * 64'(key_mul);
         step    = int'((product / divisor) % n);
         pos     = go_backward ? (idx + n - step) % n : (idx + step) % n;
         res.out_code   = LETTER_TAB[row][pos];
         res.was_letter = 1'b1;
         key_now        = key_now + 1'b1;
      end
      return res;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
         return 0;
      end
      if (r < 94) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [CODE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return 16'd1;
         end
         3, 4, 5: begin
            return 16'($urandom_range(2, 40));
         end
         default: begin
            return 16'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] random_char();
      int unsigned r;
      int unsigned pair;
      r    = $urandom_range(0, 99);
      pair = (sel_alpha <= ALPHA_LATIN) ? sel_alpha : ALPHA_UKRAINIAN;
      if (r >= 70 && r < 80) begin
         pair = $urandom_range(0, 2);
      end
      if (r < 80) begin
         return LETTER_TAB[2 * pair + $urandom_range(0, 1)]
                          [$urandom_range(0, ALPHABET_LEN[pair] - 1)];
      end
      if (r < 90) begin
         return 16'($urandom_range(16'h0020, 16'h0040));
      end
      return 16'($urandom);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      case (sel)
         CSR_ALPHABET_SELECT: begin
            sel_alpha = val[PAIR_W-1:0];
         end
         CSR_DECRYPT_MODE: begin
            go_backward = val[0];
         end
         CSR_START_KEY: begin
            key_seed = val;
         end
         CSR_KEY_MULTIPLIER: begin
            key_mul = val;
         end
         CSR_KEY_DIVISOR: begin
            key_div = val;
         end
         default: begin
         end
      endcase
      regs_written++;
   endtask

   // one transfer on the request side, predicted at acceptance
   task automatic send_char(input logic [CODE_W-1:0] code, input bit start,
                            input bit typed, input rsp_type want);
      req_type item;
      rsp_type model_out;
      item.char_code     = code;
      item.message_start = start;
      csr_we    <= 1'b0;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      model_out = encipher(item);
      pending_chars.push_back(typed ? want : model_out);
      chars_sent++;
      if (model_out.was_letter) begin
         letters_sent++;
      end
   endtask

   task automatic idle_for(input int unsigned n);
      if (n != 0) begin
         req_valid <= 1'b0;
         csr_we    <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_chars.size() == 0) begin
         $display("%0t: unexpected result, out_code %h was_letter %b",
                  $time, got.out_code, got.was_letter);
         mismatches++;
      end else begin
         want = pending_chars.pop_front();
         if (got.out_code !== want.out_code) begin
            $display("%0t: out_code expected %h, actual %h",
                     $time, want.out_code, got.out_code);
            mismatches++;
         end
         if (got.was_letter !== want.was_letter) begin
            $display("%0t: was_letter expected %b, actual %b",
                     $time, want.was_letter, got.was_letter);
            mismatches++;
         end
      end
   endtask

   // result side: random stalls plus one long hold while requests keep coming
   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = gap_len();
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : sender
      int                 count;
      int unsigned        msg_len;
      bit                 start;
      logic [CODE_W-1:0]  value;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      sel_alpha   = ALPHA_UKRAINIAN;
      go_backward = 1'b0;
      key_seed    = '0;
      key_mul     = 16'd1;
      key_div     = 16'd1;
      key_now     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].is_csr) begin
            wait_drained();
            write_reg(PLAN[i].reg_sel, PLAN[i].value);
         end else begin
            send_char(PLAN[i].value, PLAN[i].start, PLAN[i].typed, PLAN[i].want);
            idle_for(gap_len());
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         calm = (phase % 4 == 3);
         write_reg(CSR_ALPHABET_SELECT,
                   (phase < 3) ? 16'(phase) : 16'($urandom_range(0, 2)));
         write_reg(CSR_DECRYPT_MODE, 16'($urandom_range(0, 1)));
         case (phase)
            0: begin
               write_reg(CSR_START_KEY, 16'hFFFF);
               write_reg(CSR_KEY_MULTIPLIER, 16'hFFFF);
               write_reg(CSR_KEY_DIVISOR, 16'd1);
            end
            1: begin
               write_reg(CSR_START_KEY, 16'h0000);
               write_reg(CSR_KEY_MULTIPLIER, 16'h0000);
               write_reg(CSR_KEY_DIVISOR, 16'hFFFF);
            end
            default: begin
               write_reg(CSR_START_KEY, pick_value());
               write_reg(CSR_KEY_MULTIPLIER, pick_value());
               value = pick_value();
               write_reg(CSR_KEY_DIVISOR, (value == 0) ? 16'd1 : value);
            end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            msg_len = $urandom_range(1, 12);
            for (int k = 0; k < msg_len && count < PHASE_ITEMS; k++) begin
               // mostly clean messages, now and then a missing or stray start
               start = (k == 0) ? ($urandom_range(0, 9) != 0)
                                : ($urandom_range(0, 19) == 0);
               send_char(random_char(), start, 1'b0, '0);
               count++;
               if (phase == HOLD_PHASE && count == 3) begin
                  hold_request = 1'b1;
               end
               idle_for(gap_len());
            end
         end
      end

      wait_drained();
      repeat (80) @(posedge clock);
      $display("sent %0d characters, %0d of them letters, in %0d register writes",
               chars_sent, letters_sent, regs_written);
      $display("all three alphabets, both directions, extreme keys and stalls");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
